FILE: rtl/core/bde_pkg.sv
// Shared types and constants of the bounded deque engine.
package bde_pkg;

  localparam int WORD_W = 32;
  localparam int FUNC_W = 3;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 5;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;
  localparam logic [APB_AW-3:0] REG_CAP  = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_BACK   = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_FIND       = 3'd4,
    FN_READ_AT    = 3'd5,
    FN_REVERSE    = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FIND,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value_out;
    logic                     found;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
    logic                     deque_empty;
  } rsp_t;

endpackage

FILE: rtl/core/bde_req_if.sv
// Request channel: valid/ready handshake with the request item.
interface bde_req_if import bde_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] value_in;
  logic [POS_W-1:0]         position;

  modport source (output valid, func, value_in, position, input ready);
  modport sink (input valid, func, value_in, position, output ready);
endinterface

FILE: rtl/core/bde_rsp_if.sv
// Result channel: valid/ready handshake with the result item.
interface bde_rsp_if import bde_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] value_out;
  logic                     found;
  logic [1:0]               status;
  logic [CNT_W-1:0]         entry_count;
  logic                     deque_empty;

  modport source (output valid, value_out, found, status, entry_count, deque_empty,
                  input ready);
  modport sink (input valid, value_out, found, status, entry_count, deque_empty,
                output ready);
endinterface

FILE: rtl/core/bde_cfg.sv
// APB register block holding the capacity limit.
module bde_cfg import bde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  cap_limit
);

  logic hit;

  assign hit    = (paddr[APB_AW-1:2] == REG_CAP);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      cap_limit <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = hit ? {{(APB_DW-CNT_W){1'b0}}, cap_limit} : '0;

endmodule

FILE: rtl/core/bde_store.sv
// Ring store: one write port and one registered read port.
module bde_store #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/bde_ctrl.sv
// Request sequencer: pointer bookkeeping, store access and result assembly.
module bde_ctrl import bde_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  bde_req_if.sink          req,
  input  logic [CNT_W-1:0] cap_limit,
  input  logic             slot_free,
  output logic             emit,
  output rsp_t             res,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [31:0]      wr_data,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  logic [31:0]      rd_data
);

  localparam logic [CNT_W-1:0] DEPTH_CLAMP = CNT_W'((DEPTH < 32) ? DEPTH : 31);

  state_t             state, state_next;
  logic [AW-1:0]      head, head_next;
  logic [CNT_W-1:0]   occ, occ_next;
  logic               rev, rev_next;
  logic [WORD_W-1:0]  key, key_next;
  logic [WORD_W-1:0]  val, val_next;
  logic               found, found_next;
  status_t            status, status_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]   eff_cap;
  logic               at_tail;
  logic [AW-1:0]      before_head;
  logic [CNT_W-1:0]   rev_pos;

  // Wrap base + off into the ring; the sum stays below twice the depth.
  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [AW+CNT_W:0] sum;
    sum = {{(CNT_W+1){1'b0}}, base} + {{(AW+1){1'b0}}, off};
    if (sum >= (AW+CNT_W+1)'(DEPTH)) begin
      sum = sum - (AW+CNT_W+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign eff_cap     = (cap_limit > DEPTH_CLAMP) ? DEPTH_CLAMP : cap_limit;
  assign at_tail     = ((req.func == FN_PUSH_BACK) || (req.func == FN_POP_BACK)) ^ rev;
  assign before_head = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign rev_pos     = occ - 1'b1 - req.position[CNT_W-1:0];
  assign req.ready   = (state == S_IDLE);

  assign res.value_out   = val;
  assign res.found       = found;
  assign res.status      = status;
  assign res.entry_count = occ;
  assign res.deque_empty = (occ == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      occ   <= '0;
      rev   <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      occ   <= occ_next;
      rev   <= rev_next;
    end
  end

  always_ff @(posedge clk) begin
    key    <= key_next;
    val    <= val_next;
    found  <= found_next;
    status <= status_next;
    idx    <= idx_next;
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    occ_next    = occ;
    rev_next    = rev;
    key_next    = key;
    val_next    = val;
    found_next  = found;
    status_next = status;
    idx_next    = idx;
    wr_en       = 1'b0;
    wr_addr     = head;
    wr_data     = req.value_in;
    rd_en       = 1'b0;
    rd_addr     = head;
    emit        = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          key_next    = req.value_in;
          val_next    = '0;
          found_next  = 1'b0;
          status_next = ST_OK;
          idx_next    = '0;
          state_next  = S_EMIT;
          case (req.func)
            FN_PUSH_BACK, FN_PUSH_FRONT: begin
              if (occ >= eff_cap) begin
                status_next = ST_FULL;
              end else begin
                wr_en    = 1'b1;
                occ_next = occ + 1'b1;
                if (at_tail) begin
                  wr_addr = ring_at(head, occ);
                end else begin
                  wr_addr   = before_head;
                  head_next = before_head;
                end
              end
            end
            FN_POP_BACK, FN_POP_FRONT: begin
              if (occ == '0) begin
                status_next = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                occ_next   = occ - 1'b1;
                state_next = S_READ;
                if (at_tail) begin
                  rd_addr = ring_at(head, occ - 1'b1);
                end else begin
                  head_next = ring_at(head, CNT_W'(1));
                end
              end
            end
            FN_FIND: begin
              // Scan physical offsets from the head; order is irrelevant.
              if (occ != '0) begin
                rd_en      = 1'b1;
                state_next = S_FIND;
              end
            end
            FN_READ_AT: begin
              if ({{(POS_W-CNT_W){1'b0}}, occ} > req.position) begin
                rd_en      = 1'b1;
                rd_addr    = rev ? ring_at(head, rev_pos)
                                 : ring_at(head, req.position[CNT_W-1:0]);
                state_next = S_READ;
              end else begin
                status_next = ST_RANGE;
              end
            end
            FN_REVERSE: begin
              if (occ != '0) begin
                rev_next = ~rev;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        val_next   = rd_data;
        state_next = S_EMIT;
      end
      S_FIND: begin
        if (rd_data == key) begin
          found_next = 1'b1;
          state_next = S_EMIT;
        end else if (idx == occ - 1'b1) begin
          state_next = S_EMIT;
        end else begin
          idx_next = idx + 1'b1;
          rd_en    = 1'b1;
          rd_addr  = ring_at(head, idx + 1'b1);
        end
      end
      S_EMIT: begin
        emit = slot_free;
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/bounded_deque_engine.sv
// Top level of the bounded deque engine: config port, sequencer, store, result register.
//
// A bounded double-ended queue of signed 32-bit words kept in a DEPTH-entry
// ring store (one synchronous memory with a registered read) with a head
// pointer, a count and a reversal flag. One request item is worked at a time
// and yields one result item, which sits in an output register so the next
// request is taken while the result still waits. Push, reverse, unused codes,
// a find on an empty queue and every full/empty/range case go straight to the
// result; pop and read-at first wait on the registered read of the store; find
// compares the entries, one per cycle through the single read port, until a
// hit or the end. A result still held in the output register by a stalled sink
// adds its wait. Capacity is cap_limit (APB register at byte 0, reset 10),
// clamped to DEPTH. The store needs no clearing after reset: only written
// entries are ever returned.
module bounded_deque_engine import bde_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  bde_req_if.sink           req,
  bde_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(DEPTH);

  logic [CNT_W-1:0] cap_limit;
  logic             emit;
  logic             slot_free;
  rsp_t             res;
  rsp_t             rsp_q;
  logic             rsp_valid;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [31:0]      wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [31:0]      rd_data;

  bde_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cap_limit (cap_limit)
  );

  bde_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cap_limit (cap_limit),
    .slot_free (slot_free),
    .emit      (emit),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  bde_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The output register frees up in the same cycle its item is taken.
  assign slot_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Load the payload only on emit; hold it while the sink stalls.
  always_ff @(posedge clk) begin
    if (emit) begin
      rsp_q <= res;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.value_out   = rsp_q.value_out;
  assign rsp.found       = rsp_q.found;
  assign rsp.status      = rsp_q.status;
  assign rsp.entry_count = rsp_q.entry_count;
  assign rsp.deque_empty = rsp_q.deque_empty;

  // One item in flight: after an accept, hold off the next one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while previous item still in work");

  // The count can never pass the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (32'(rsp.entry_count) <= DEPTH))
    else $error("entry count exceeds store depth");

  // An empty status only comes from an empty queue.
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_EMPTY) |-> rsp.deque_empty && (rsp.entry_count == '0))
    else $error("empty status on a non-empty queue");

  // A hit needs at least one entry and reports ok.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> (rsp.entry_count != '0) && (rsp.status == ST_OK))
    else $error("found flag with empty queue or error status");

endmodule
